/* hdl/mfp_pkg.sv */
// ----------------------------------------------------------------------------
// mfp_pkg: shared types and constants for the motor feedback frame parser
// Register map, frame position codes and the structs that pass between the
// configuration registers, the frame parser and the result register.
// ----------------------------------------------------------------------------
package mfp_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register indexes, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_HEADER      = 3'd0,
    REG_TAIL        = 3'd1,
    REG_FIRST_ADDR  = 3'd2,
    REG_SECOND_ADDR = 3'd3,
    REG_LOW_TYPE    = 3'd4,
    REG_HIGH_TYPE   = 3'd5
  } reg_idx_t;

  // Byte positions inside a nine-byte frame.
  localparam logic [3:0] POS_HUNT    = 4'd0;
  localparam logic [3:0] POS_ADDR    = 4'd1;
  localparam logic [3:0] POS_TYPE    = 4'd2;
  localparam logic [3:0] POS_VAL_FIRST = 4'd3;
  localparam logic [3:0] POS_VAL_LAST  = 4'd6;
  localparam logic [3:0] POS_CHECK   = 4'd7;
  localparam logic [3:0] POS_TAIL    = 4'd8;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] tail_byte;
    logic [7:0] first_motor_address;
    logic [7:0] second_motor_address;
    logic [7:0] lowest_type_code;
    logic [7:0] highest_type_code;
  } cfg_t;

  typedef struct packed {
    logic               motor_select;
    logic [7:0]         feedback_type;
    logic signed [31:0] feedback_value;
  } result_t;

endpackage

/* hdl/mfp_regs.sv */
// ----------------------------------------------------------------------------
// mfp_regs: configuration register file
// Six 8-bit registers behind an APB-style port; writes to unused indexes
// are dropped, reads of them return zero.
// ----------------------------------------------------------------------------
module mfp_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mfp_pkg::ADDR_W-1:0]  paddr,
  input  logic [mfp_pkg::DATA_W-1:0]  pwdata,
  output logic [mfp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output mfp_pkg::cfg_t               cfg
);
  import mfp_pkg::*;

  logic       wr_en;
  logic [2:0] idx;
  logic [7:0] rd_byte;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte          <= 8'd0;
      cfg.tail_byte            <= 8'd0;
      cfg.first_motor_address  <= 8'd1;
      cfg.second_motor_address <= 8'd2;
      cfg.lowest_type_code     <= 8'd0;
      cfg.highest_type_code    <= 8'd4;
    end else if (wr_en) begin
      case (idx)
        REG_HEADER:      cfg.header_byte          <= pwdata[7:0];
        REG_TAIL:        cfg.tail_byte            <= pwdata[7:0];
        REG_FIRST_ADDR:  cfg.first_motor_address  <= pwdata[7:0];
        REG_SECOND_ADDR: cfg.second_motor_address <= pwdata[7:0];
        REG_LOW_TYPE:    cfg.lowest_type_code     <= pwdata[7:0];
        REG_HIGH_TYPE:   cfg.highest_type_code    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HEADER:      rd_byte = cfg.header_byte;
      REG_TAIL:        rd_byte = cfg.tail_byte;
      REG_FIRST_ADDR:  rd_byte = cfg.first_motor_address;
      REG_SECOND_ADDR: rd_byte = cfg.second_motor_address;
      REG_LOW_TYPE:    rd_byte = cfg.lowest_type_code;
      REG_HIGH_TYPE:   rd_byte = cfg.highest_type_code;
      default:         rd_byte = 8'd0;
    endcase
  end

  assign prdata = {{(DATA_W-8){1'b0}}, rd_byte};

endmodule

/* hdl/mfp_parse.sv */
// ----------------------------------------------------------------------------
// mfp_parse: frame position tracker and running XOR check
// Consumes one byte whenever take is high and flags a completed, valid frame
// in the same cycle, together with its decoded fields.
// ----------------------------------------------------------------------------
module mfp_parse (
  input  logic              clk,
  input  logic              rst,
  input  mfp_pkg::cfg_t     cfg,
  input  logic              take,
  input  logic [7:0]        rx_byte,
  output logic              res_hit,
  output mfp_pkg::result_t  res
);
  import mfp_pkg::*;

  logic [3:0]  pos, pos_next;
  logic [7:0]  check, check_next;
  logic [7:0]  frame_address, frame_address_next;
  logic [7:0]  frame_type, frame_type_next;
  logic [31:0] value_shift, value_shift_next;
  logic [7:0]  received_check, received_check_next;
  logic        is_header;

  assign is_header = (rx_byte == cfg.header_byte);

  always_comb begin
    pos_next            = pos;
    check_next          = check;
    frame_address_next  = frame_address;
    frame_type_next     = frame_type;
    value_shift_next    = value_shift;
    received_check_next = received_check;
    res_hit             = 1'b0;
    case (pos)
      POS_ADDR: begin
        if (rx_byte == cfg.first_motor_address ||
            rx_byte == cfg.second_motor_address) begin
          frame_address_next = rx_byte;
          check_next         = check ^ rx_byte;
          pos_next           = POS_TYPE;
        end else begin
          pos_next   = is_header ? POS_ADDR : POS_HUNT;
          check_next = is_header ? rx_byte : 8'd0;
        end
      end
      POS_TYPE: begin
        if (rx_byte >= cfg.lowest_type_code && rx_byte <= cfg.highest_type_code) begin
          frame_type_next = rx_byte;
          check_next      = check ^ rx_byte;
          pos_next        = POS_VAL_FIRST;
        end else begin
          pos_next   = is_header ? POS_ADDR : POS_HUNT;
          check_next = is_header ? rx_byte : 8'd0;
        end
      end
      POS_CHECK: begin
        received_check_next = rx_byte;
        pos_next            = POS_TAIL;
      end
      POS_TAIL: begin
        res_hit    = (rx_byte == cfg.tail_byte) && (received_check == check);
        pos_next   = POS_HUNT;
        check_next = 8'd0;
      end
      default: begin
        if (pos inside {[POS_VAL_FIRST:POS_VAL_LAST]}) begin
          value_shift_next = {value_shift[23:0], rx_byte};
          check_next       = check ^ rx_byte;
          pos_next         = pos + 4'd1;
        end else begin
          // Hunting, or a position that cannot occur: look for a header.
          pos_next   = is_header ? POS_ADDR : POS_HUNT;
          check_next = is_header ? rx_byte : 8'd0;
        end
      end
    endcase
  end

  assign res.motor_select   = (frame_address != cfg.first_motor_address);
  assign res.feedback_type  = frame_type;
  assign res.feedback_value = value_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= POS_HUNT;
      check <= 8'd0;
    end else if (take) begin
      pos   <= pos_next;
      check <= check_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      frame_address  <= frame_address_next;
      frame_type     <= frame_type_next;
      value_shift    <= value_shift_next;
      received_check <= received_check_next;
    end
  end

  p_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= POS_TAIL)
    else $error("frame position left the nine-byte range");
  p_hit_only_at_tail: assert property (@(posedge clk) disable iff (rst)
    res_hit |-> pos == POS_TAIL)
    else $error("frame accepted away from the tail position");
  p_tail_returns_hunt: assert property (@(posedge clk) disable iff (rst)
    take && pos == POS_TAIL |=> pos == POS_HUNT && check == 8'd0)
    else $error("parser did not return to hunting after a tail byte");

endmodule

/* hdl/mfp_out.sv */
// ----------------------------------------------------------------------------
// mfp_out: result register
// Holds one decoded frame until the downstream side takes it.
// ----------------------------------------------------------------------------
module mfp_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  mfp_pkg::result_t  res,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [31:0]       m_tdata,  // [31:0] feedback_value
  output logic [8:0]        m_tuser,  // [0] motor_select, [8:1] feedback_type
  output logic              free
);
  import mfp_pkg::*;

  result_t held;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = held.feedback_value;
  assign m_tuser = {held.feedback_type, held.motor_select};

endmodule

/* hdl/motor_feedback_frame_parser.sv */
// ----------------------------------------------------------------------------
// motor_feedback_frame_parser: nine-byte motor feedback frame parser
// Hunts a received byte stream for feedback frames and emits one beat per
// frame that passes the address, type, XOR check and tail tests.
// ----------------------------------------------------------------------------
// Usage:
//   The slave side takes one received byte per beat in s_tdata[7:0]. The
//   master side gives one beat per good frame: the signed 32-bit value in
//   m_tdata, the motor select in m_tuser[0] and the type code in
//   m_tuser[8:1]. Motor select is 0 when the frame address equals the first
//   motor address and 1 otherwise.
//   Each byte is captured in an input register and handled by the parser
//   once the result register is free; a tail byte that completes a good
//   frame loads the result register, where the result is held. One byte is
//   taken every cycle while the master side is not stalled; the single
//   result register is the only limit on rate.
//   When the receiver holds m_tready low with a result pending, the input
//   register keeps one more byte and s_tready drops until the result goes.
//   Reset clears both registers, returns the parser to hunting for a header
//   and loads the register defaults (header 0, tail 0, motor addresses 1
//   and 2, type range 0 to 4). The APB-style port writes registers at byte
//   addresses 0, 4, ... 20; write them only while no byte is in flight.
// ----------------------------------------------------------------------------
module motor_feedback_frame_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,   // [31:0] feedback_value
  output logic [8:0]                  m_tuser,   // [0] motor_select, [8:1] feedback_type
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mfp_pkg::ADDR_W-1:0]  paddr,
  input  logic [mfp_pkg::DATA_W-1:0]  pwdata,
  output logic [mfp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import mfp_pkg::*;

  cfg_t       cfg;
  result_t    res;
  logic       res_hit;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_free;
  logic       advance;

  mfp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The byte in the input register moves into the parser whenever the
  // result register can take whatever it might produce.
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  mfp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .take    (advance),
    .rx_byte (in_byte),
    .res_hit (res_hit),
    .res     (res)
  );

  mfp_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res_hit),
    .res      (res),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .free     (out_free)
  );

  p_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && !in_valid)
    else $error("pipeline not empty after reset");
  p_held_byte_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("stalled input byte was lost or changed");
  p_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("pending result overwritten while the receiver stalled");

endmodule

/* tb/motor_feedback_frame_parser_test.sv */
// ----------------------------------------------------------------------------
// motor_feedback_frame_parser_test: self-checking bench for the frame parser
// Feeds received bytes through the slave stream port, mixes well-formed
// frames with corrupted, truncated and noise traffic, and compares every
// result beat with a behavioral parser kept inside the bench. Register
// settings change between traffic phases through the APB-style port.
// ----------------------------------------------------------------------------
module motor_feedback_frame_parser_test;
  import mfp_pkg::*;

  // Cycles to let the input register and the parser settle once no result
  // is outstanding.
  localparam int DRAIN_CYCLES = 6;
  // Length of the one long receiver hold-off, in clock cycles.
  localparam int LONG_HOLD_CYCLES = 400;
  // Byte budget of the random traffic in each register phase.
  localparam int PHASE_BYTES = 63;
  localparam int PHASE_COUNT = 9;
  localparam int DIRECTED_LEN = 31;

  // Register slots past the end of the map; writes there must be ignored.
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  localparam cfg_t RESET_CFG = '{8'h00, 8'h00, 8'h01, 8'h02, 8'h00, 8'h04};

  // How a directed row is judged: by the bench parser, or by a result
  // (or the lack of one) typed into the row itself.
  typedef enum logic [1:0] {
    ROW_CHECKED,
    ROW_NO_RESULT,
    ROW_RESULT
  } row_kind_t;

  typedef struct packed {
    logic [7:0] rx;
    row_kind_t  kind;
    result_t    want;
  } stim_row_t;

  typedef enum logic [2:0] {
    FRAME_GOOD,
    FRAME_BAD_ADDR,
    FRAME_BAD_TYPE,
    FRAME_BAD_CHECK,
    FRAME_BAD_TAIL,
    FRAME_CUT,
    FRAME_NOISE
  } frame_kind_t;

  typedef enum logic [1:0] {
    SINK_ALWAYS,
    SINK_COIN,
    SINK_SPARSE,
    SINK_PERIODIC
  } sink_mode_t;

  // Directed bytes, all under the reset register values (header 0, tail 0,
  // motors 1 and 2, types 0 to 4).
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    // Good frame for the first motor carrying the most negative value.
    '{8'h00, ROW_CHECKED, '0}, '{8'h01, ROW_CHECKED, '0}, '{8'h00, ROW_CHECKED, '0},
    '{8'h80, ROW_CHECKED, '0}, '{8'h00, ROW_CHECKED, '0}, '{8'h00, ROW_CHECKED, '0},
    '{8'h00, ROW_CHECKED, '0}, '{8'h81, ROW_CHECKED, '0},
    '{8'h00, ROW_RESULT, '{1'b0, 8'h00, 32'sh80000000}},
    // A bad address that equals the header restarts the frame at the
    // address byte; the frame that follows is good, second motor, top type
    // code, most positive value.
    '{8'h00, ROW_CHECKED, '0}, '{8'h00, ROW_CHECKED, '0}, '{8'h02, ROW_CHECKED, '0},
    '{8'h04, ROW_CHECKED, '0}, '{8'h7F, ROW_CHECKED, '0}, '{8'hFF, ROW_CHECKED, '0},
    '{8'hFF, ROW_CHECKED, '0}, '{8'hFF, ROW_CHECKED, '0}, '{8'h86, ROW_CHECKED, '0},
    '{8'h00, ROW_RESULT, '{1'b1, 8'h04, 32'sh7FFFFFFF}},
    // Type code one past the range, not a header: back to hunting.
    '{8'h00, ROW_CHECKED, '0}, '{8'h01, ROW_CHECKED, '0}, '{8'h05, ROW_NO_RESULT, '0},
    // Wrong check byte (the right one would be 0x09): no result.
    '{8'h00, ROW_CHECKED, '0}, '{8'h02, ROW_CHECKED, '0}, '{8'h03, ROW_CHECKED, '0},
    '{8'h12, ROW_CHECKED, '0}, '{8'h34, ROW_CHECKED, '0}, '{8'h56, ROW_CHECKED, '0},
    '{8'h78, ROW_CHECKED, '0}, '{8'hFF, ROW_CHECKED, '0}, '{8'h00, ROW_NO_RESULT, '0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = 8'h00;     // [7:0] rx_byte
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [31:0]       m_tdata;             // [31:0] feedback_value
  logic [8:0]        m_tuser;             // [0] motor_select, [8:1] feedback_type
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  motor_feedback_frame_parser uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  // Register values as the bench believes the block holds them.
  cfg_t shadow_cfg = RESET_CFG;

  // Bench copy of the parser state.
  logic [3:0]  frame_pos = POS_HUNT;
  logic [7:0]  xor_acc = 8'h00;
  logic [7:0]  held_address = 8'h00;
  logic [7:0]  held_type = 8'h00;
  logic [31:0] value_acc = 32'h0;
  logic [7:0]  held_check = 8'h00;

  // Results still owed by the block, oldest first.
  result_t pending_feedback_q [$];
  int      mismatch_count = 0;

  // Sender burst bookkeeping.
  int burst_left = 0;

  // Receiver stall pattern and the long hold-off handshake between the
  // stimulus process and the receiver process.
  int         hold_requests = 0;
  int         hold_served = 0;
  int         hold_left = 0;
  int         sink_mode_left = 0;
  sink_mode_t sink_mode = SINK_ALWAYS;
  logic [2:0] sink_tick = 3'd0;

  // Steps the bench parser by one received byte. A frame is header, address,
  // type, four big-endian value bytes, an XOR check over the first seven
  // bytes, and the tail. Each test uses the registers as they are now.
  task automatic parse_rx_byte(input logic [7:0] b, output bit got, output result_t r);
    got = 1'b0;
    r = '0;
    if (frame_pos == POS_HUNT || frame_pos > POS_TAIL) begin
      frame_pos = (b == shadow_cfg.header_byte) ? POS_ADDR : POS_HUNT;
      xor_acc = (b == shadow_cfg.header_byte) ? b : 8'h00;
    end else if (frame_pos == POS_ADDR) begin
      if (b != shadow_cfg.first_motor_address && b != shadow_cfg.second_motor_address) begin
        // A rejected byte may itself open the next frame.
        frame_pos = (b == shadow_cfg.header_byte) ? POS_ADDR : POS_HUNT;
        xor_acc = (b == shadow_cfg.header_byte) ? b : 8'h00;
      end else begin
        held_address = b;
        xor_acc ^= b;
        frame_pos = POS_TYPE;
      end
    end else if (frame_pos == POS_TYPE) begin
      if (b < shadow_cfg.lowest_type_code || b > shadow_cfg.highest_type_code) begin
        frame_pos = (b == shadow_cfg.header_byte) ? POS_ADDR : POS_HUNT;
        xor_acc = (b == shadow_cfg.header_byte) ? b : 8'h00;
      end else begin
        held_type = b;
        xor_acc ^= b;
        frame_pos = POS_VAL_FIRST;
      end
    end else if (frame_pos <= POS_VAL_LAST) begin
      value_acc = {value_acc[23:0], b};
      xor_acc ^= b;
      frame_pos = frame_pos + 4'd1;
    end else if (frame_pos == POS_CHECK) begin
      held_check = b;
      frame_pos = POS_TAIL;
    end else begin
      // Tail position. A bad tail is never taken as a new header.
      if (b == shadow_cfg.tail_byte && held_check == xor_acc) begin
        got = 1'b1;
        r.motor_select = (held_address == shadow_cfg.first_motor_address) ? 1'b0 : 1'b1;
        r.feedback_type = held_type;
        r.feedback_value = value_acc;
      end
      frame_pos = POS_HUNT;
      xor_acc = 8'h00;
    end
  endtask

  // Offers one byte, with the random burst and gap pattern of the sender,
  // waits for the beat, and runs the bench parser on it.
  task automatic push_byte(input logic [7:0] b, output bit got, output result_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    parse_rx_byte(b, got, r);
  endtask

  task automatic send_rx_byte(input logic [7:0] b);
    bit      got;
    result_t r;
    push_byte(b, got, r);
    if (got) pending_feedback_q.push_back(r);
  endtask

  // Stops the sender and waits until every owed result has been taken and
  // the block has had time to finish with the last byte.
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_feedback_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle. pready is always high,
  // so the access ends at the next edge. The bus then goes idle, so that
  // transfers never overlap their bus updates.
  task automatic apb_access(input logic [2:0] idx, input bit write_en, input logic [7:0] wval,
                            output logic [7:0] rval);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write_en;
    paddr <= {idx, 2'b00};
    // Junk in the upper bits must not matter to an 8-bit register.
    pwdata <= {24'($urandom), wval};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rval = prdata[7:0];
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] v);
    logic [7:0] unused;
    apb_access(idx, 1'b1, v, unused);
    case (idx)
      REG_HEADER:      shadow_cfg.header_byte = v;
      REG_TAIL:        shadow_cfg.tail_byte = v;
      REG_FIRST_ADDR:  shadow_cfg.first_motor_address = v;
      REG_SECOND_ADDR: shadow_cfg.second_motor_address = v;
      REG_LOW_TYPE:    shadow_cfg.lowest_type_code = v;
      REG_HIGH_TYPE:   shadow_cfg.highest_type_code = v;
      default: ;
    endcase
  endtask

  // Reads every mapped register back and compares it with the shadow copy.
  task automatic verify_registers();
    logic [7:0] got_val;
    logic [7:0] want_val;
    reg_idx_t   idx;
    idx = idx.first();
    forever begin
      apb_access(idx, 1'b0, 8'h00, got_val);
      case (idx)
        REG_HEADER:      want_val = shadow_cfg.header_byte;
        REG_TAIL:        want_val = shadow_cfg.tail_byte;
        REG_FIRST_ADDR:  want_val = shadow_cfg.first_motor_address;
        REG_SECOND_ADDR: want_val = shadow_cfg.second_motor_address;
        REG_LOW_TYPE:    want_val = shadow_cfg.lowest_type_code;
        default:         want_val = shadow_cfg.highest_type_code;
      endcase
      if (got_val !== want_val) begin
        mismatch_count++;
        $error("register %s: expected %0h, actual %0h", idx.name(), want_val, got_val);
      end
      if (idx == idx.last()) break;
      idx = idx.next();
    end
  endtask

  task automatic program_settings(input cfg_t c);
    write_reg(REG_HEADER, c.header_byte);
    write_reg(REG_TAIL, c.tail_byte);
    write_reg(REG_FIRST_ADDR, c.first_motor_address);
    write_reg(REG_SECOND_ADDR, c.second_motor_address);
    write_reg(REG_LOW_TYPE, c.lowest_type_code);
    write_reg(REG_HIGH_TYPE, c.highest_type_code);
    // Slots past the map; the read-back below shows they clobbered nothing.
    write_reg(REG_SPARE_A, 8'($urandom));
    write_reg(REG_SPARE_B, 8'($urandom));
    verify_registers();
  endtask

  // Sends one frame built for the current registers, spoiled as the kind
  // asks. Returns the number of frame bytes sent; noise counts as none.
  task automatic send_frame(input frame_kind_t kind, output int sent);
    logic [7:0]  fb [9];
    logic [31:0] val;
    int          len;
    int          pick;
    pick = $urandom_range(0, 7);
    case (pick)
      0:       val = 32'h8000_0000;
      1:       val = 32'h7FFF_FFFF;
      2:       val = 32'h0000_0000;
      3:       val = 32'hFFFF_FFFF;
      default: val = $urandom;
    endcase
    fb[0] = shadow_cfg.header_byte;
    fb[1] = $urandom_range(0, 1) ? shadow_cfg.second_motor_address
                                 : shadow_cfg.first_motor_address;
    if (shadow_cfg.lowest_type_code <= shadow_cfg.highest_type_code)
      fb[2] = 8'($urandom_range(shadow_cfg.lowest_type_code, shadow_cfg.highest_type_code));
    else
      fb[2] = 8'($urandom);
    fb[3] = val[31:24];
    fb[4] = val[23:16];
    fb[5] = val[15:8];
    fb[6] = val[7:0];
    fb[7] = fb[0] ^ fb[1] ^ fb[2] ^ fb[3] ^ fb[4] ^ fb[5] ^ fb[6];
    fb[8] = shadow_cfg.tail_byte;
    len = 9;
    case (kind)
      FRAME_BAD_ADDR: begin
        // Half the time try the header, so the restart path gets used.
        do fb[1] = $urandom_range(0, 1) ? shadow_cfg.header_byte : 8'($urandom);
        while (fb[1] == shadow_cfg.first_motor_address ||
               fb[1] == shadow_cfg.second_motor_address);
      end
      FRAME_BAD_TYPE: begin
        // A type range covering every code cannot be missed.
        if (!(shadow_cfg.lowest_type_code == 8'h00 && shadow_cfg.highest_type_code == 8'hFF)) begin
          do fb[2] = $urandom_range(0, 1) ? shadow_cfg.header_byte : 8'($urandom);
          while (fb[2] >= shadow_cfg.lowest_type_code && fb[2] <= shadow_cfg.highest_type_code);
        end
      end
      FRAME_BAD_CHECK: fb[7] ^= 8'($urandom_range(1, 255));
      FRAME_BAD_TAIL:  fb[8] ^= 8'($urandom_range(1, 255));
      FRAME_CUT:       len = $urandom_range(1, 8);
      FRAME_NOISE: begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          fb[i] = ($urandom_range(0, 3) == 0) ? shadow_cfg.header_byte : 8'($urandom);
      end
      default: ;
    endcase
    for (int i = 0; i < len; i++) send_rx_byte(fb[i]);
    sent = (kind == FRAME_NOISE) ? 0 : len;
  endtask

  // Good frames with random content half the time; the rest is broken frames and
  // noise that leave the parser in every position between phases.
  task automatic random_traffic(input int budget);
    int          sent;
    int          total;
    int          roll;
    frame_kind_t kind;
    total = 0;
    while (total < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 50)      kind = FRAME_GOOD;
      else if (roll < 58) kind = FRAME_BAD_ADDR;
      else if (roll < 66) kind = FRAME_BAD_TYPE;
      else if (roll < 74) kind = FRAME_BAD_CHECK;
      else if (roll < 82) kind = FRAME_BAD_TAIL;
      else if (roll < 90) kind = FRAME_CUT;
      else                kind = FRAME_NOISE;
      send_frame(kind, sent);
      total += sent;
    end
  endtask

  // Receiver: switches among random stall patterns, and
  // serves the long hold-off when the stimulus asks for one. The hold is
  // counted here so the sender keeps offering bytes meanwhile.
  always @(posedge clk) begin
    sink_tick <= sink_tick + 3'd1;
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (sink_mode_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        sink_mode_left = $urandom_range(20, 200);
      end
      sink_mode_left--;
      case (sink_mode)
        SINK_ALWAYS:   m_tready <= 1'b1;
        SINK_COIN:     m_tready <= 1'($urandom_range(0, 1));
        SINK_SPARSE:   m_tready <= ($urandom_range(0, 9) == 0);
        default:       m_tready <= (sink_tick[1:0] != 2'd0);
      endcase
    end
  end

  // Result checker: every accepted result beat must match the oldest owed
  // result, field by field. Values are sampled as they stood at the edge.
  result_t want;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_feedback_q.size() == 0) begin
        mismatch_count++;
        $error("unexpected result beat: motor_select %0d, feedback_type %0h, feedback_value %0d",
               m_tuser[0], m_tuser[8:1], $signed(m_tdata));
      end else begin
        want = pending_feedback_q.pop_front();
        if (m_tuser[0] !== want.motor_select) begin
          mismatch_count++;
          $error("motor_select: expected %0d, actual %0d", want.motor_select, m_tuser[0]);
        end
        if (m_tuser[8:1] !== want.feedback_type) begin
          mismatch_count++;
          $error("feedback_type: expected %0h, actual %0h", want.feedback_type, m_tuser[8:1]);
        end
        if (m_tdata !== want.feedback_value) begin
          mismatch_count++;
          $error("feedback_value: expected %0d, actual %0d", want.feedback_value,
                 $signed(m_tdata));
        end
      end
    end
  end

  // Main sequence: directed bytes under the reset registers, then random
  // traffic over a series of register settings. Each change of settings
  // waits for the block to drain, which also serves as the sender pause
  // until every owed result has come. The parser state is kept across a
  // change, so frames often straddle it.
  initial begin
    cfg_t    plan [PHASE_COUNT];
    bit      got;
    result_t r;

    plan[0] = RESET_CFG;
    // Extremes: all-ones framing bytes, motor addresses at both ends, and a
    // type range that takes every code.
    plan[1] = '{8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
    // Both motor addresses the same, and a single accepted type code.
    plan[2] = '{8'hA5, 8'h5A, 8'h10, 8'h10, 8'h03, 8'h03};
    // Empty type range: every frame dies at its type byte.
    plan[3] = '{8'h3C, 8'hC3, 8'h01, 8'h02, 8'h80, 8'h7F};
    for (int p = 4; p < PHASE_COUNT; p++) begin
      plan[p].header_byte = 8'($urandom);
      plan[p].tail_byte = 8'($urandom);
      plan[p].first_motor_address = 8'($urandom);
      plan[p].second_motor_address = ($urandom_range(0, 4) == 0) ?
                                     plan[p].first_motor_address : 8'($urandom);
      plan[p].lowest_type_code = 8'($urandom_range(0, 200));
      plan[p].highest_type_code = 8'($urandom_range(plan[p].lowest_type_code, 255));
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p == 0) begin
        verify_registers();
        for (int i = 0; i < DIRECTED_LEN; i++) begin
          push_byte(DIRECTED_ROWS[i].rx, got, r);
          case (DIRECTED_ROWS[i].kind)
            ROW_RESULT:  pending_feedback_q.push_back(DIRECTED_ROWS[i].want);
            ROW_CHECKED: if (got) pending_feedback_q.push_back(r);
            default: ;
          endcase
        end
      end else begin
        wait_quiet();
        program_settings(plan[p]);
        // Ask the receiver for its long hold-off while bytes keep coming, so
        // the result register fills and the input side has to stall.
        if (p == 5) hold_requests++;
      end
      random_traffic(PHASE_BYTES);
    end

    wait_quiet();
    if (mismatch_count == 0 && pending_feedback_q.size() == 0) begin
      $display("motor_feedback_frame_parser_test passed");
    end else begin
      $display("motor_feedback_frame_parser_test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("motor_feedback_frame_parser_test failed");
    $finish;
  end

endmodule
